// ----- sv/mrwr_pkg.sv -----
`default_nettype none

package mrwr_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int REFL_W           = 16;
    localparam int MASK_W           = 8;
    localparam int SLOT_W           = 4;
    localparam int ACC_W            = 21;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 16;

    // Division by nine: floor(x / 9) == (x * DIV9_MUL) >> DIV9_SHIFT for x < 2**21.
    localparam int               DIV9_SHIFT = 24;
    localparam logic [ACC_W-1:0] DIV9_MUL   = 21'd1864136;
    localparam logic [ACC_W-1:0] ROUND_HALF = 21'd4;

    localparam logic [REFL_W-1:0] REFL_FILL_RESET = 16'hD8F1;
    localparam logic [MASK_W-1:0] MASK_FILL_RESET = 8'hFF;

    typedef enum logic [1:0] {
        CMD_BOX      = 2'd0,
        CMD_WEIGHTED = 2'd1,
        CMD_MASK     = 2'd2,
        CMD_UNUSED   = 2'd3
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] REG_REFL_FILL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_FILL = 2'd1;

    typedef struct packed {
        t_cmd                      command;
        logic signed [REFL_W-1:0]  refl_sample;
        logic [MASK_W-1:0]         mask_byte;
        logic [SLOT_W-1:0]         slot;
        logic                      row_phase;
        logic                      col_phase;
        logic                      last;
    } t_in;

    typedef struct packed {
        logic signed [REFL_W-1:0]  out_value;
        logic                      out_is_fill;
    } t_out;

    typedef struct packed {
        logic                      is_mask;
        logic                      fill;
        logic signed [ACC_W-1:0]   sum;
        logic [MASK_W-1:0]         mask_byte;
    } t_win;

endpackage

`default_nettype wire

// ----- sv/mrwr_acc.sv -----
`default_nettype none

module mrwr_acc #(
    parameter int SAMPLE_WIDTH = mrwr_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  mrwr_pkg::t_in                     i_in_data,
    output logic                              o_in_stall,
    input  logic [mrwr_pkg::REFL_W-1:0]       i_refl_fill,
    input  logic [mrwr_pkg::MASK_W-1:0]       i_mask_fill,
    output logic                              o_win_valid,
    output mrwr_pkg::t_win                    o_win,
    input  logic                              i_win_stall
);
    import mrwr_pkg::*;

    logic                      r_in_valid;
    t_in                       r_in;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_fill;
    logic [5:0]                r_bits;
    logic [1:0]                r_level;
    logic                      r_win_valid;
    t_win                      r_win;

    logic signed [ACC_W-1:0]   n_acc;
    logic                      n_fill;
    logic [5:0]                n_bits;
    logic [1:0]                n_level;

    logic                      is_refl;
    logic                      is_mask;
    logic                      is_unused;
    logic                      win_free;
    logic                      in_take;
    logic                      step;
    logic                      win_load;
    logic signed [SAMPLE_WIDTH-1:0] sample_s;
    logic signed [ACC_W-1:0]   sample_ext;
    logic signed [ACC_W-1:0]   contrib;
    logic [1:0]                shift;

    assign is_refl   = (r_in.command == CMD_BOX) || (r_in.command == CMD_WEIGHTED);
    assign is_mask   = (r_in.command == CMD_MASK);
    assign is_unused = (r_in.command == CMD_UNUSED);

    assign win_free   = !r_win_valid || !i_win_stall;
    assign in_take    = r_in_valid && (is_unused || !r_in.last || win_free);
    assign o_in_stall = r_in_valid && !in_take;
    assign step       = in_take && !is_unused;
    assign win_load   = step && r_in.last;

    always_comb begin
        sample_s   = r_in.refl_sample[SAMPLE_WIDTH-1:0];
        sample_ext = ACC_W'(sample_s);
        shift      = 2'd0;
        if (r_in.command == CMD_WEIGHTED) begin
            shift = 2'(r_in.slot[1] == r_in.row_phase) + 2'(r_in.slot[0] == r_in.col_phase);
        end
        contrib = sample_ext <<< shift;

        n_acc   = is_refl ? r_acc + contrib : r_acc;
        n_fill  = r_fill
                  || (is_refl && (r_in.refl_sample[SAMPLE_WIDTH-1:0]
                                  == i_refl_fill[SAMPLE_WIDTH-1:0]))
                  || (is_mask && (r_in.mask_byte == i_mask_fill));
        n_bits  = is_mask ? (r_bits | r_in.mask_byte[5:0]) : r_bits;
        n_level = (is_mask && (r_in.mask_byte[7:6] > r_level)) ? r_in.mask_byte[7:6] : r_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_acc       <= '0;
            r_fill      <= 1'b0;
            r_bits      <= '0;
            r_level     <= '0;
            r_win_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (step) begin
                if (r_in.last) begin
                    r_acc   <= '0;
                    r_fill  <= 1'b0;
                    r_bits  <= '0;
                    r_level <= '0;
                end else begin
                    r_acc   <= n_acc;
                    r_fill  <= n_fill;
                    r_bits  <= n_bits;
                    r_level <= n_level;
                end
            end
            if (win_load) begin
                r_win_valid <= 1'b1;
            end else if (!i_win_stall) begin
                r_win_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_data;
        end
        if (win_load) begin
            r_win.is_mask   <= is_mask;
            r_win.fill      <= n_fill;
            r_win.sum       <= n_acc;
            r_win.mask_byte <= {n_level, n_bits};
        end
    end

    assign o_win_valid = r_win_valid;
    assign o_win       = r_win;

endmodule

`default_nettype wire

// ----- sv/mrwr_div9.sv -----
`default_nettype none

module mrwr_div9 #(
    parameter int SAMPLE_WIDTH = mrwr_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_win_valid,
    input  mrwr_pkg::t_win                    i_win,
    output logic                              o_win_stall,
    input  logic [mrwr_pkg::REFL_W-1:0]       i_refl_fill,
    input  logic [mrwr_pkg::MASK_W-1:0]       i_mask_fill,
    output logic                              o_out_valid,
    output mrwr_pkg::t_out                    o_out_data,
    input  logic                              i_out_stall
);
    import mrwr_pkg::*;

    localparam int PROD_W = 2 * ACC_W;
    localparam int QA_W   = PROD_W - DIV9_SHIFT;
    localparam int QS_W   = QA_W + 1;
    localparam logic signed [QS_W-1:0] Q_HI = QS_W'((2 ** (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [QS_W-1:0] Q_LO = -Q_HI - QS_W'(1);

    typedef struct packed {
        logic [ACC_W-1:0]   mag;
        logic               neg;
        logic               is_mask;
        logic               fill;
        logic [MASK_W-1:0]  mask_byte;
    } t_div;

    logic                      r_div_valid;
    t_div                      r_div;
    logic                      r_out_valid;
    t_out                      r_out;

    logic                      out_free;
    logic                      div_free;
    logic [ACC_W-1:0]          abs_sum;
    logic [PROD_W-1:0]         prod;
    logic [QA_W-1:0]           qa;
    logic signed [QS_W-1:0]    qs;
    logic signed [QS_W-1:0]    sat;
    logic signed [SAMPLE_WIDTH-1:0] fill_s;
    logic signed [REFL_W-1:0]  n_value;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign div_free    = !r_div_valid || out_free;
    assign o_win_stall = !div_free;

    assign abs_sum = i_win.sum[ACC_W-1] ? ACC_W'(-i_win.sum) : ACC_W'(i_win.sum);

    always_comb begin
        prod = PROD_W'(r_div.mag) * PROD_W'(DIV9_MUL);
        qa   = prod[PROD_W-1:DIV9_SHIFT];
        qs   = r_div.neg ? -QS_W'(qa) : QS_W'(qa);
        if (qs > Q_HI) begin
            sat = Q_HI;
        end else if (qs < Q_LO) begin
            sat = Q_LO;
        end else begin
            sat = qs;
        end
        fill_s = i_refl_fill[SAMPLE_WIDTH-1:0];
        if (r_div.is_mask) begin
            n_value = r_div.fill ? REFL_W'(i_mask_fill) : REFL_W'(r_div.mask_byte);
        end else begin
            n_value = r_div.fill ? REFL_W'(fill_s) : sat[REFL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (div_free) begin
                r_div_valid <= i_win_valid;
            end
            if (out_free) begin
                r_out_valid <= r_div_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_free) begin
            r_div.mag       <= abs_sum + ROUND_HALF;
            r_div.neg       <= i_win.sum[ACC_W-1];
            r_div.is_mask   <= i_win.is_mask;
            r_div.fill      <= i_win.fill;
            r_div.mask_byte <= i_win.mask_byte;
        end
        if (out_free) begin
            r_out.out_value   <= n_value;
            r_out.out_is_fill <= r_div.fill;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- sv/multires_window_resampler.sv -----
// A window's result passes through the window, divide and output registers after the edge that accepts its last sample.
// Throughput: one sample per cycle while no stall comes back from the output, set by the accumulator update.
// The divide by nine runs as a two-stage reciprocal multiply behind the accumulator.
// Reset is synchronous and active low: it empties all stages, clears the window state
// and loads the fill registers with -9999 and 255; no clearing pass follows.
`default_nettype none

module multires_window_resampler #(
    parameter int SAMPLE_WIDTH = mrwr_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  mrwr_pkg::t_in                       i_in_data,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output mrwr_pkg::t_out                      o_out_data,
    input  logic                                i_out_stall,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mrwr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mrwr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import mrwr_pkg::*;

    logic [REFL_W-1:0] r_refl_fill;
    logic [MASK_W-1:0] r_mask_fill;
    logic              win_valid;
    t_win              win;
    logic              win_stall;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refl_fill <= REFL_FILL_RESET;
            r_mask_fill <= MASK_FILL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_REFL_FILL: begin
                    r_refl_fill <= i_cfg_data[REFL_W-1:0];
                end
                REG_MASK_FILL: begin
                    r_mask_fill <= i_cfg_data[MASK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    mrwr_acc #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_refl_fill (r_refl_fill),
        .i_mask_fill (r_mask_fill),
        .o_win_valid (win_valid),
        .o_win       (win),
        .i_win_stall (win_stall)
    );

    mrwr_div9 #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_div9 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_win_valid (win_valid),
        .i_win       (win),
        .o_win_stall (win_stall),
        .i_refl_fill (r_refl_fill),
        .i_mask_fill (r_mask_fill),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

// ----- tb/tb_multires_window_resampler.sv -----
`default_nettype none

module tb_multires_window_resampler;
    timeunit 1ns;
    timeprecision 1ps;

    import mrwr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_BEATS  = 170;
    localparam int PHASES       = 5;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        t_in  beat;
        logic typed;
        t_out want;
    } t_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in                   i_in_data   = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out                  o_out_data;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    logic beat_typed = 1'b0;
    t_out beat_want  = '0;
    logic calm       = 1'b0;

    logic signed [REFL_W-1:0] refl_fill_m = REFL_FILL_RESET;
    logic [MASK_W-1:0]        mask_fill_m = MASK_FILL_RESET;
    logic signed [ACC_W-1:0]  win_sum     = '0;
    logic                     win_fill    = 1'b0;
    logic [5:0]               win_bits    = '0;
    logic [1:0]               win_level   = '0;

    t_out expected_pixels[$];
    t_row script[$];
    int   bad_pixels = 0;
    int   cycle_cnt  = 0;
    int   beats_sent = 0;

    multires_window_resampler DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5ns i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 10);
    end

    function automatic void clear_window();
        win_sum   = '0;
        win_fill  = 1'b0;
        win_bits  = '0;
        win_level = '0;
    endfunction

    function automatic logic signed [REFL_W-1:0] div9_round(input logic signed [ACC_W-1:0] s);
        int sv;
        int q;
        sv = int'(s);
        q  = (sv < 0) ? -((-sv + 4) / 9) : (sv + 4) / 9;
        if (q > 32767)
            q = 32767;
        else if (q < -32768)
            q = -32768;
        return q[REFL_W-1:0];
    endfunction

    // Folds one accepted beat into the window; a pixel comes out only on a last beat.
    function automatic logic predict_pixel(input t_in b, output t_out px);
        logic signed [ACC_W-1:0] term;
        int                      shift;
        px = '0;
        if (b.command == CMD_UNUSED)
            return 1'b0;
        if (b.command == CMD_MASK) begin
            if (b.mask_byte == mask_fill_m)
                win_fill = 1'b1;
            win_bits = win_bits | b.mask_byte[5:0];
            if (b.mask_byte[7:6] > win_level)
                win_level = b.mask_byte[7:6];
        end else begin
            term = ACC_W'(b.refl_sample);
            if (b.refl_sample == refl_fill_m)
                win_fill = 1'b1;
            if (b.command == CMD_WEIGHTED) begin
                shift = int'(b.slot[1] == b.row_phase) + int'(b.slot[0] == b.col_phase);
                term  = term <<< shift;
            end
            win_sum = win_sum + term;
        end
        if (!b.last)
            return 1'b0;
        px.out_is_fill = win_fill;
        if (b.command == CMD_MASK)
            px.out_value = win_fill ? {8'h00, mask_fill_m} : {8'h00, win_level, win_bits};
        else
            px.out_value = win_fill ? refl_fill_m : div9_round(win_sum);
        clear_window();
        return 1'b1;
    endfunction

    function automatic void report_mismatch(input string msg);
        bad_pixels++;
        if (bad_pixels <= 10)
            $display("%s", msg);
    endfunction

    always @(posedge i_clk) begin : watch
        t_out px;
        t_out want;
        if (!i_rst_n) begin
            refl_fill_m = REFL_FILL_RESET;
            mask_fill_m = MASK_FILL_RESET;
            clear_window();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_REFL_FILL)
                    refl_fill_m = i_cfg_data;
                else if (i_cfg_index == REG_MASK_FILL)
                    mask_fill_m = i_cfg_data[MASK_W-1:0];
            end
            if (i_in_valid && !o_in_stall) begin
                if (predict_pixel(i_in_data, px))
                    expected_pixels.push_back(beat_typed ? beat_want : px);
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("unexpected pixel: value %0d fill %0b",
                                              o_out_data.out_value, o_out_data.out_is_fill));
                end else begin
                    want = expected_pixels.pop_front();
                    if (o_out_data.out_value !== want.out_value
                        || o_out_data.out_is_fill !== want.out_is_fill)
                        report_mismatch($sformatf(
                            "pixel mismatch: value %0d fill %0b, expected value %0d fill %0b",
                            o_out_data.out_value, o_out_data.out_is_fill,
                            want.out_value, want.out_is_fill));
                end
            end
        end
    end

    function automatic t_row mk_beat(input t_cmd cmd, input int sample, input int mb,
                                     input int slot, input bit rph, input bit cph,
                                     input bit lst, input bit typed = 1'b0,
                                     input int value = 0, input bit fill = 1'b0);
        t_row r;
        r.beat.command     = cmd;
        r.beat.refl_sample = sample[REFL_W-1:0];
        r.beat.mask_byte   = mb[MASK_W-1:0];
        r.beat.slot        = slot[SLOT_W-1:0];
        r.beat.row_phase   = rph;
        r.beat.col_phase   = cph;
        r.beat.last        = lst;
        r.typed            = typed;
        r.want.out_value   = value[REFL_W-1:0];
        r.want.out_is_fill = fill;
        return r;
    endfunction

    function automatic int rand_refl();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            return int'(refl_fill_m);
        if (pick < 12)
            return 32767;
        if (pick < 20)
            return -32768;
        if (pick < 35)
            return int'($urandom_range(0, 40)) - 20;
        return $urandom_range(0, 65535);
    endfunction

    function automatic int rand_mask();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return int'(mask_fill_m);
        if (pick < 10)
            return 0;
        if (pick < 15)
            return 255;
        return $urandom_range(0, 255);
    endfunction

    // A stalled beat keeps its payload; a gap lowers valid only between beats.
    task automatic send_beat(input t_row r);
        if (!calm && $urandom_range(0, 99) < 5) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r.beat;
        beat_typed <= r.typed;
        beat_want  <= r.want;
        do @(posedge i_clk); while (o_in_stall);
        if (r.beat.command != CMD_UNUSED)
            beats_sent++;
    endtask

    task automatic send_window();
        int   pick;
        int   len;
        int   big;
        bit   rph;
        bit   cph;
        t_cmd cmd;
        pick = $urandom_range(0, 99);
        rph  = 1'($urandom_range(0, 1));
        cph  = 1'($urandom_range(0, 1));
        if (pick < 28) begin
            for (int k = 0; k < 9; k++)
                send_beat(mk_beat(CMD_BOX, rand_refl(), $urandom_range(0, 255), k,
                                  rph, cph, k == 8));
        end else if (pick < 52) begin
            for (int k = 0; k < 4; k++)
                send_beat(mk_beat(CMD_WEIGHTED, rand_refl(), $urandom_range(0, 255), k,
                                  rph, cph, k == 3));
        end else if (pick < 76) begin
            for (int k = 0; k < 9; k++)
                send_beat(mk_beat(CMD_MASK, $urandom_range(0, 65535), rand_mask(), k,
                                  rph, cph, k == 8));
        end else if (pick < 86) begin
            len = $urandom_range(6, 12);
            big = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            for (int k = 0; k < len; k++)
                send_beat(mk_beat(CMD_WEIGHTED,
                                  ($urandom_range(0, 4) == 0) ? rand_refl() : big,
                                  $urandom_range(0, 255),
                                  int'($urandom_range(0, 3)) * 4 + rph * 2 + cph,
                                  rph, cph, k == len - 1));
        end else begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
                cmd = t_cmd'($urandom_range(0, 3));
                send_beat(mk_beat(cmd, rand_refl(), rand_mask(), $urandom_range(0, 15),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  k == len - 1 || $urandom_range(0, 9) == 0));
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic settle();
        @(posedge i_clk);
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int refl_set[PHASES];
        int mask_set[PHASES];
        int stop;
        refl_set    = '{-32768, 32767, 0, 0, -9999};
        mask_set    = '{0, 255, 128, 0, 255};
        refl_set[3] = int'($urandom_range(0, 65535)) - 32768;
        mask_set[3] = $urandom_range(0, 255);

        script.push_back(mk_beat(CMD_BOX, 0, 8'h00, 0, 0, 0, 1, 1, 0, 0));
        script.push_back(mk_beat(CMD_BOX, 9, 8'hFF, 15, 1, 1, 1, 1, 1, 0));
        script.push_back(mk_beat(CMD_BOX, 5, 8'h00, 0, 0, 0, 1));
        script.push_back(mk_beat(CMD_BOX, -5, 8'h00, 0, 0, 0, 1));
        script.push_back(mk_beat(CMD_BOX, -9999, 8'h00, 0, 0, 0, 1, 1, -9999, 1));
        for (int k = 0; k < 4; k++)
            script.push_back(mk_beat(CMD_WEIGHTED, 100, 8'h00, k, 0, 0, k == 3, 1, 100, 0));
        for (int k = 0; k < 4; k++)
            script.push_back(mk_beat(CMD_WEIGHTED, 32767, 8'h00, (k % 2) * 8, 0, 0, k == 3,
                                     1, 32767, 0));
        for (int k = 0; k < 4; k++)
            script.push_back(mk_beat(CMD_WEIGHTED, -32768, 8'h00, 3 + (k % 2) * 8, 1, 1,
                                     k == 3, 1, -32768, 0));
        script.push_back(mk_beat(CMD_MASK, 0, 8'h41, 0, 0, 0, 0));
        script.push_back(mk_beat(CMD_MASK, 0, 8'h82, 1, 0, 0, 0));
        script.push_back(mk_beat(CMD_MASK, 0, 8'h04, 2, 0, 0, 1, 1, 8'h87, 0));
        script.push_back(mk_beat(CMD_MASK, 0, 8'hFF, 0, 0, 0, 1, 1, 255, 1));
        script.push_back(mk_beat(CMD_UNUSED, 12345, 8'h00, 15, 1, 1, 1));
        script.push_back(mk_beat(CMD_BOX, 18, 8'h00, 0, 0, 0, 1, 1, 2, 0));
        script.push_back(mk_beat(CMD_BOX, 90, 8'h00, 0, 0, 0, 0));
        script.push_back(mk_beat(CMD_MASK, 0, 8'h3F, 0, 0, 0, 1, 1, 63, 0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[n])
            send_beat(script[n]);
        i_in_valid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_reg(REG_REFL_FILL, refl_set[p][CFG_DATA_W-1:0]);
            write_reg(REG_MASK_FILL, {8'($urandom_range(0, 255)), 8'(mask_set[p])});
            i_cfg_valid <= 1'b0;
            calm = (p == 2);
            stop = beats_sent + PHASE_BEATS;
            while (beats_sent < stop)
                send_window();
            i_in_valid <= 1'b0;
        end
        calm = 1'b0;
        settle();

        if (bad_pixels == 0 && expected_pixels.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
